[sv/ffa_pkg.sv]
// Shared constants and types for the first-fit heap allocator.
package ffa_pkg;

  localparam int HDR_BYTES = 4;

  localparam int SIZE_W = 12;
  localparam int ADDR_W = 13;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WALK  = 8'b0000_0010,
    S_HDR   = 8'b0000_0100,
    S_CWALK = 8'b0000_1000,
    S_CHDR  = 8'b0001_0000,
    S_FIT   = 8'b0010_0000,
    S_SPLIT = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

endpackage

[sv/ffa_req_if.sv]
// Request channel of the allocator: one word per allocate or free.
interface ffa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [ffa_pkg::SIZE_W-1:0]    size;
  logic [ffa_pkg::ADDR_W-1:0]    address;

  modport source (output valid, output mode, output size, output address, input ready);
  modport sink (input valid, input mode, input size, input address, output ready);
endinterface

[sv/ffa_rsp_if.sv]
// Response channel of the allocator: one word per request.
interface ffa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffa_pkg::ADDR_W-1:0]    block_offset;
  logic [ffa_pkg::STAT_W-1:0]    status;

  modport source (output valid, output block_offset, output status, input ready);
  modport sink (input valid, input block_offset, input status, output ready);
endinterface

[sv/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator with in-band block headers.
// This block manages an arena of ARENA_BYTES bytes tiled by blocks, each opening
// with a header that holds a free mark and a payload length. Only headers
// are kept: they live in one synchronous memory indexed by byte position,
// one entry per position, so a header may start at any byte. An allocate
// word walks the header chain from position zero; at each free block it
// folds the free blocks that follow into it, then takes the first block
// whose payload fits, splitting off the remainder as a new free block when
// that remainder exceeds one header. A free word walks the same chain to
// the header just before the given payload offset and marks it free;
// coalescing waits for later allocates. Every request gives one response
// word. The request word is taken in the idle state, and each header
// visited on the walk takes a read-issue state, then a decide state. At a
// free block every following header examined takes the read-issue and decide
// states, whether it is folded in or ends the fold (only the read-issue state
// when the arena end is reached instead), and a fit state compares the grown
// block with the size. A grant that splits adds a write state, and a final
// state hands the response over, held while the previous response still
// waits. The cost is thus set by the heap layout and the single read port of
// the header memory. A new request is taken while the previous response
// still waits in the output register. No clearing pass is needed after reset.
module first_fit_heap_allocator #(
  parameter int ARENA_BYTES = 4096
) (
  input  logic clk,
  input  logic rst,
  ffa_req_if.sink   req,
  ffa_rsp_if.source rsp
);
  import ffa_pkg::*;

  // Positions and lengths both range up to the arena size.
  localparam int AW = $clog2(ARENA_BYTES);
  localparam int PW = $clog2(ARENA_BYTES + 1);
  localparam int DW = PW + 1;
  localparam logic [31:0] LAST_HDR = 32'(ARENA_BYTES - HDR_BYTES);
  localparam logic [DW-1:0] RST_WORD = {1'b1, PW'(ARENA_BYTES - HDR_BYTES)};

  state_t            state;
  logic              mode;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] address;
  logic [PW-1:0]     pos;    // header being examined
  logic [PW-1:0]     nxt;    // header following the block being grown
  logic [PW-1:0]     acc;    // payload length of the block being grown
  logic [ADDR_W-1:0] res_off;
  logic [STAT_W-1:0] res_st;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  ffa_hdr_mem #(.AW(AW), .DW(DW), .RST_WORD(RST_WORD)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Header read back this cycle, with its length clamped to the arena end.
  logic          h_free;
  logic [31:0]   h_len;
  logic [31:0]   room;
  logic [31:0]   clen;
  logic [31:0]   base;
  logic [31:0]   pos32;
  logic [31:0]   nxt32;
  logic [31:0]   acc32;
  logic [31:0]   size32;
  logic [31:0]   grown;

  always_comb begin
    pos32  = 32'(pos);
    nxt32  = 32'(nxt);
    acc32  = 32'(acc);
    size32 = 32'(size);
    base   = state[4] ? nxt32 : pos32;
    h_free = mem_rdata[DW-1];
    h_len  = 32'(mem_rdata[PW-1:0]);
    room   = LAST_HDR - base;
    clen   = (h_len > room) ? room : h_len;
    grown  = acc32 + 32'(HDR_BYTES) + clen;
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[AW-1:0];
    mem_wdata = '0;
    mem_raddr = pos[AW-1:0];
    unique case (state)
      S_CWALK: mem_raddr = nxt[AW-1:0];
      S_HDR: begin
        // Free of an allocated block whose payload is the given offset.
        if (mode == MODE_FREE && pos32 + 32'(HDR_BYTES) == 32'(address) && !h_free) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, mem_rdata[PW-1:0]};
        end
      end
      S_CHDR: begin
        if (h_free) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, grown[PW-1:0]};
        end
      end
      S_FIT: begin
        if (acc32 >= size32) begin
          mem_we    = 1'b1;
          mem_wdata = (acc32 > size32 + 32'(HDR_BYTES)) ? {1'b0, size32[PW-1:0]}
                                                        : {1'b0, acc};
        end
      end
      S_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos32 + 32'(HDR_BYTES) + size32);
        mem_wdata = {1'b1, PW'(acc32 - size32 - 32'(HDR_BYTES))};
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // A response taken while the next one is handed over stays valid.
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode    <= req.mode;
            size    <= req.size;
            address <= req.address;
            pos     <= '0;
            res_off <= '0;
            res_st  <= (req.mode == MODE_FREE) ? ST_REJECT : ST_NOFIT;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          // The walk ends once no full header fits before the arena end.
          state <= (pos32 <= LAST_HDR) ? S_HDR : S_FIN;
        end
        S_HDR: begin
          if (mode == MODE_FREE) begin
            if (pos32 + 32'(HDR_BYTES) > 32'(address)) begin
              state <= S_FIN;
            end else if (pos32 + 32'(HDR_BYTES) == 32'(address)) begin
              if (!h_free) begin
                res_st <= ST_DONE;
              end
              state <= S_FIN;
            end else begin
              pos   <= PW'(pos32 + 32'(HDR_BYTES) + clen);
              state <= S_WALK;
            end
          end else if (h_free) begin
            acc   <= PW'(clen);
            nxt   <= PW'(pos32 + 32'(HDR_BYTES) + clen);
            state <= S_CWALK;
          end else begin
            pos   <= PW'(pos32 + 32'(HDR_BYTES) + clen);
            state <= S_WALK;
          end
        end
        S_CWALK: begin
          state <= (nxt32 <= LAST_HDR) ? S_CHDR : S_FIT;
        end
        S_CHDR: begin
          // Fold a following free block into the one at pos.
          if (h_free) begin
            acc   <= PW'(grown);
            nxt   <= PW'(pos32 + 32'(HDR_BYTES) + grown);
            state <= S_CWALK;
          end else begin
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (acc32 >= size32) begin
            res_off <= ADDR_W'(pos32 + 32'(HDR_BYTES));
            res_st  <= ST_DONE;
            state   <= (acc32 > size32 + 32'(HDR_BYTES)) ? S_SPLIT : S_FIN;
          end else begin
            pos   <= PW'(pos32 + 32'(HDR_BYTES) + acc32);
            state <= S_WALK;
          end
        end
        S_SPLIT: state <= S_FIN;
        S_FIN: begin
          // Hand the response over once the output register is free.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.block_offset <= res_off;
            rsp.status       <= res_st;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/ffa_hdr_mem.sv]
// Header store indexed by byte position, with the reset header at position zero.
module ffa_hdr_mem #(
  parameter int AW = 12,
  parameter int DW = 14,
  parameter logic [DW-1:0] RST_WORD = '0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1<<AW)];
  logic [DW-1:0] q;
  logic          zero_written;
  logic          rd_reset;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

  // Position zero reads as the reset header until it is first written.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_written <= 1'b0;
      rd_reset     <= 1'b0;
    end else begin
      if (we && waddr == '0) begin
        zero_written <= 1'b1;
      end
      rd_reset <= (raddr == '0) && !zero_written;
    end
  end

  assign rdata = rd_reset ? RST_WORD : q;

endmodule
